[hdl/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, hold off while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/srqs_pkg.sv]
`default_nettype none

package srqs_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int RANK_W = 11;
  localparam int VAL_W = 32;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                    func;
    logic signed [VAL_W-1:0] record_value;
    logic                    start_new_set;
    logic [RANK_W-1:0]       query_rank;
    logic                    from_largest;
  } srqs_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] answer_value;
    logic                    rank_error;
  } srqs_rsp_t;

  typedef struct packed {
    logic                    load;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic [IDX_W-1:0]        rd_idx;
  } srqs_ctl_t;

endpackage

`default_nettype wire

[hdl/srqs_cell.sv]
`default_nettype none

module srqs_cell (
  input  wire logic                             clk,
  input  wire srqs_pkg::srqs_ctl_t              ctl,
  input  wire logic [srqs_pkg::IDX_W-1:0]       cell_idx,
  input  wire logic signed [srqs_pkg::VAL_W-1:0] prev_rec,
  input  wire logic                             prev_after,
  input  wire logic signed [srqs_pkg::VAL_W-1:0] prev_rv,
  output logic signed [srqs_pkg::VAL_W-1:0]     rec,
  output logic                                  after,
  output logic signed [srqs_pkg::VAL_W-1:0]     rv
);
  import srqs_pkg::*;

  logic occupied;

  assign occupied = {1'b0, cell_idx} < ctl.count;
  assign after = !occupied || (rec > ctl.value);

  // shift up behind the insertion point, take the new record at it
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (prev_after) begin
        rec <= prev_rec;
      end else if (after) begin
        rec <= ctl.value;
      end
    end
  end

  // pass the read token along, replace it at the selected cell
  always_ff @(posedge clk) begin
    if (ctl.rd_idx == cell_idx) begin
      rv <= rec;
    end else begin
      rv <= prev_rv;
    end
  end

endmodule

`default_nettype wire

[hdl/srqs_chain.sv]
`default_nettype none

module srqs_chain (
  input  wire logic                         clk,
  input  wire srqs_pkg::srqs_ctl_t          ctl,
  output logic signed [srqs_pkg::VAL_W-1:0] rd_value
);
  import srqs_pkg::*;

  logic signed [VAL_W-1:0] rec_link [0:MAX_RECORDS];
  logic                    after_link [0:MAX_RECORDS];
  logic signed [VAL_W-1:0] rv_link [0:MAX_RECORDS];

  assign rec_link[0] = '0;
  assign after_link[0] = 1'b0;
  assign rv_link[0] = '0;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    srqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (IDX_W'(i)),
      .prev_rec   (rec_link[i]),
      .prev_after (after_link[i]),
      .prev_rv    (rv_link[i]),
      .rec        (rec_link[i+1]),
      .after      (after_link[i+1]),
      .rv         (rv_link[i+1])
    );
  end

  assign rd_value = rv_link[MAX_RECORDS];

endmodule

`default_nettype wire

[hdl/sorted_rank_query_store.sv]
// Load transaction: stored at its accept edge unless full and start_new_set low;
// one load per cycle while idle, no response. Query transaction: the read token
// walks the cell row one cell per cycle in ST_SCAN, then ST_DONE loads the
// response; errors skip ST_SCAN. One query is in flight at a time.
// Reset: record count cleared and response slot empty; record cells keep
// undefined contents until loaded, with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module sorted_rank_query_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire srqs_pkg::srqs_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output srqs_pkg::srqs_rsp_t      rsp
);
  import srqs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] scan_cnt;
  logic             q_err;
  logic             accept;
  logic             do_load;
  logic             do_query;
  logic             bad_rank;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] sel;
  logic             rsp_load;
  srqs_ctl_t        ctl;
  logic signed [VAL_W-1:0] rd_value;

  assign req_ready = (state == ST_IDLE);
  assign accept = req_valid && req_ready;
  assign do_query = accept && (req.func == FUNC_QUERY);
  assign eff_count = req.start_new_set ? '0 : count;
  assign do_load = accept && (req.func == FUNC_LOAD) &&
                   (req.start_new_set || (count < CNT_W'(MAX_RECORDS)));
  assign bad_rank = (req.query_rank == '0) || (req.query_rank > RANK_W'(count));
  assign sel = req.from_largest ? (count - CNT_W'(req.query_rank))
                                : (CNT_W'(req.query_rank) - CNT_W'(1));
  assign count_next = do_load ? eff_count + CNT_W'(1) : count;

  assign ctl.load = do_load;
  assign ctl.value = req.record_value;
  assign ctl.count = eff_count;
  assign ctl.rd_idx = rd_idx;

  srqs_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .rd_value (rd_value)
  );

  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_query) begin
          state_next = bad_rank ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      rd_idx <= sel[IDX_W-1:0];
      q_err <= bad_rank;
      scan_cnt <= IDX_W'(MAX_RECORDS - 1);
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt - IDX_W'(1);
    end
    if (rsp_load) begin
      rsp.answer_value <= q_err ? '0 : rd_value;
      rsp.rank_error <= q_err;
    end
  end

  `ASSERT_CLK(a_count_max, count <= CNT_W'(MAX_RECORDS), "record count above capacity")
  `ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid) |-> $past(state == ST_DONE), "response without query")
  `ASSERT_CLK(a_scan_end, (state == ST_SCAN) && (scan_cnt == '0) |=> (state == ST_DONE), "scan overrun")
  `ASSERT_CLK(a_full_drop, accept && (req.func == FUNC_LOAD) && !req.start_new_set && (count == CNT_W'(MAX_RECORDS)) |=> (count == CNT_W'(MAX_RECORDS)), "load into full store kept")

endmodule

`default_nettype wire
